FILE: design/iels_pkg.sv
// Package for the input event latch sampler.
// Holds word types, event and phase codes, button bit constants and helpers.
// No dependencies.
`default_nettype none

package iels_pkg;

   localparam int unsigned BUTTON_BITS = 16;
   localparam int unsigned LEFT_BIT    = 0;
   localparam int unsigned RIGHT_BIT   = 1;
   localparam int unsigned UP_BIT      = 2;
   localparam int unsigned DOWN_BIT    = 3;
   localparam int unsigned CIRCLE_BIT  = 4;

   localparam int unsigned BTN_W   = 16;
   localparam int unsigned THR_W   = 15;
   localparam int unsigned ACC_W   = 18;
   localparam logic [THR_W-1:0] THR_RESET = 15'd256;
   localparam logic [THR_W-1:0] THR_ONE   = 15'd256;

   localparam logic [BTN_W-1:0] BTN_MASK =
      (BUTTON_BITS >= BTN_W) ? {BTN_W{1'b1}} : BTN_W'((64'd1 << BUTTON_BITS) - 64'd1);

   localparam logic [2:0] FUNC_KEY     = 3'd0;
   localparam logic [2:0] FUNC_PULSE   = 3'd1;
   localparam logic [2:0] FUNC_MOTION  = 3'd2;
   localparam logic [2:0] FUNC_PRIMARY = 3'd3;
   localparam logic [2:0] FUNC_TOUCH   = 3'd4;
   localparam logic [2:0] FUNC_SAMPLE  = 3'd5;

   localparam logic [1:0] PHASE_DOWN   = 2'd0;
   localparam logic [1:0] PHASE_MOVE   = 2'd1;
   localparam logic [1:0] PHASE_UP     = 2'd2;
   localparam logic [1:0] PHASE_CANCEL = 2'd3;

   typedef struct packed {
      logic [2:0]         func;
      logic [15:0]        button_mask;
      logic               key_down;
      logic               key_repeat;
      logic signed [15:0] delta_x;
      logic signed [15:0] delta_y;
      logic [1:0]         touch_phase;
      logic [7:0]         contact_id;
      logic signed [15:0] touch_x_in;
      logic signed [15:0] touch_y_in;
   } req_word_type;

   typedef struct packed {
      logic [15:0]        buttons_out;
      logic               touch_active;
      logic signed [15:0] touch_x_out;
      logic signed [15:0] touch_y_out;
   } rsp_word_type;

   // single button bit, dropped when outside the button width
   function automatic logic [BTN_W-1:0] bit_of(input int unsigned b);
      logic [BTN_W-1:0] r;
      r = '0;
      if (b < BUTTON_BITS && b < BTN_W) begin
         r[b[3:0]] = 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/input_event_latch_sampler.sv
// Input event latch sampler, top level.
// Path: an accepted sample word passes the input register, then the result register, to rsp.
// Throughput: one word per cycle; the input register keeps taking words
// while a sample result waits on rsp_stall, until a second sample queues.
// Reset: synchronous; clears all state but the held data words, threshold returns to 1.0 (256).
// Depends on iels_pkg, iels_input_reg, iels_state_core.
`default_nettype none

module input_event_latch_sampler (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  iels_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output iels_pkg::rsp_word_type rsp_word,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [14:0]           csr_wdata
);
   import iels_pkg::*;

   logic         s1_valid;
   req_word_type s1_word;
   logic         advance;

   assign csr_ready = 1'b1;

   iels_input_reg u_input_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .advance   (advance),
      .s1_valid  (s1_valid),
      .s1_word   (s1_word)
   );

   iels_state_core u_state_core (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_word   (s1_word),
      .advance   (advance),
      .csr_valid (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

FILE: design/iels_input_reg.sv
// Input register stage of the input event latch sampler.
// Depends on iels_pkg.
`default_nettype none

module iels_input_reg (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  iels_pkg::req_word_type req_word,
   input  wire                   advance,
   output logic                  s1_valid,
   output iels_pkg::req_word_type s1_word
);
   import iels_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   req_word_type s1_word_ff, s1_word_in;
   logic         accept;

   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign s1_valid  = s1_valid_ff;
   assign s1_word   = s1_word_ff;

   always_comb begin
      s1_word_in = s1_word_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_word_in  = req_word;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_word_ff <= s1_word_in;
   end

endmodule

`default_nettype wire

FILE: design/iels_state_core.sv
// Event state update and result register of the input event latch sampler.
// Holds the button, trackball and touch state and the threshold register.
// Depends on iels_pkg.
`default_nettype none

module iels_state_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   s1_valid,
   input  iels_pkg::req_word_type s1_word,
   output logic                  advance,
   input  wire                   csr_valid,
   input  wire  [14:0]           csr_wdata,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output iels_pkg::rsp_word_type rsp_word
);
   import iels_pkg::*;

   logic [BTN_W-1:0]        held_bits_ff, held_bits_in;
   logic [BTN_W-1:0]        press_latch_ff, press_latch_in;
   logic                    primary_held_ff, primary_held_in;
   logic signed [ACC_W-1:0] accum_x_ff, accum_x_in;
   logic signed [ACC_W-1:0] accum_y_ff, accum_y_in;
   logic                    contact_valid_ff, contact_valid_in;
   logic [7:0]              contact_owner_ff, contact_owner_in;
   logic                    contact_down_ff, contact_down_in;
   logic                    contact_latched_ff, contact_latched_in;
   logic signed [15:0]      pos_x_ff, pos_x_in;
   logic signed [15:0]      pos_y_ff, pos_y_in;
   logic [THR_W-1:0]        threshold_ff, threshold_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_word_type            rsp_word_ff, rsp_word_in;

   logic                    fire;
   logic [BTN_W-1:0]        mask;
   logic [THR_W-1:0]        th;
   logic signed [ACC_W-1:0] th_pos, th_neg, sum_x, sum_y;
   logic                    owned;

   assign advance   = !(s1_word.func == FUNC_SAMPLE && rsp_valid_ff && rsp_stall);
   assign fire      = s1_valid && advance;
   assign mask      = s1_word.button_mask & BTN_MASK;
   assign th        = (threshold_ff == '0) ? THR_ONE : threshold_ff;
   assign th_pos    = ACC_W'(signed'({1'b0, th}));
   assign th_neg    = -th_pos;
   assign sum_x     = accum_x_ff + ACC_W'(s1_word.delta_x);
   assign sum_y     = accum_y_ff + ACC_W'(s1_word.delta_y);
   assign owned     = contact_valid_ff && (contact_owner_ff == s1_word.contact_id);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      held_bits_in       = held_bits_ff;
      press_latch_in     = press_latch_ff;
      primary_held_in    = primary_held_ff;
      accum_x_in         = accum_x_ff;
      accum_y_in         = accum_y_ff;
      contact_valid_in   = contact_valid_ff;
      contact_owner_in   = contact_owner_ff;
      contact_down_in    = contact_down_ff;
      contact_latched_in = contact_latched_ff;
      pos_x_in           = pos_x_ff;
      pos_y_in           = pos_y_ff;
      threshold_in       = csr_valid ? csr_wdata : threshold_ff;
      rsp_word_in        = rsp_word_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;

      if (fire) begin
         unique case (s1_word.func)
            FUNC_KEY: begin
               if (mask != '0) begin
                  if (s1_word.key_down) begin
                     held_bits_in = held_bits_ff | mask;
                     if (!s1_word.key_repeat) begin
                        press_latch_in = press_latch_ff | mask;
                     end
                  end else begin
                     held_bits_in = held_bits_ff & ~mask;
                  end
               end
            end
            FUNC_PULSE: begin
               press_latch_in = press_latch_ff | mask;
            end
            FUNC_MOTION: begin
               accum_x_in = sum_x;
               accum_y_in = sum_y;
               if (sum_x <= th_neg) begin
                  press_latch_in = press_latch_in | bit_of(LEFT_BIT);
                  accum_x_in     = '0;
               end else if (sum_x >= th_pos) begin
                  press_latch_in = press_latch_in | bit_of(RIGHT_BIT);
                  accum_x_in     = '0;
               end
               if (sum_y <= th_neg) begin
                  press_latch_in = press_latch_in | bit_of(UP_BIT);
                  accum_y_in     = '0;
               end else if (sum_y >= th_pos) begin
                  press_latch_in = press_latch_in | bit_of(DOWN_BIT);
                  accum_y_in     = '0;
               end
            end
            FUNC_PRIMARY: begin
               if (s1_word.key_down && !primary_held_ff) begin
                  press_latch_in = press_latch_ff | bit_of(CIRCLE_BIT);
               end
               primary_held_in = s1_word.key_down;
            end
            FUNC_TOUCH: begin
               case (s1_word.touch_phase)
                  PHASE_DOWN: begin
                     if (!contact_valid_ff || owned) begin
                        contact_valid_in   = 1'b1;
                        contact_owner_in   = s1_word.contact_id;
                        contact_down_in    = 1'b1;
                        contact_latched_in = 1'b1;
                        pos_x_in           = s1_word.touch_x_in;
                        pos_y_in           = s1_word.touch_y_in;
                     end
                  end
                  PHASE_MOVE, PHASE_UP: begin
                     if (owned) begin
                        pos_x_in = s1_word.touch_x_in;
                        pos_y_in = s1_word.touch_y_in;
                        if (s1_word.touch_phase == PHASE_UP) begin
                           contact_down_in = 1'b0;
                        end
                     end
                  end
                  default: begin
                     contact_valid_in   = 1'b0;
                     contact_owner_in   = '0;
                     contact_down_in    = 1'b0;
                     contact_latched_in = 1'b0;
                  end
               endcase
            end
            FUNC_SAMPLE: begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.buttons_out  = held_bits_ff | press_latch_ff |
                                          (primary_held_ff ? bit_of(CIRCLE_BIT) : '0);
               rsp_word_in.touch_active = contact_down_ff || contact_latched_ff;
               rsp_word_in.touch_x_out  = pos_x_ff;
               rsp_word_in.touch_y_out  = pos_y_ff;
               press_latch_in           = '0;
               contact_latched_in       = 1'b0;
               if (!contact_down_ff) begin
                  contact_valid_in = 1'b0;
                  contact_owner_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bits_ff       <= '0;
         press_latch_ff     <= '0;
         primary_held_ff    <= 1'b0;
         accum_x_ff         <= '0;
         accum_y_ff         <= '0;
         contact_valid_ff   <= 1'b0;
         contact_owner_ff   <= '0;
         contact_down_ff    <= 1'b0;
         contact_latched_ff <= 1'b0;
         pos_x_ff           <= '0;
         pos_y_ff           <= '0;
         threshold_ff       <= THR_RESET;
         rsp_valid_ff       <= 1'b0;
      end else begin
         held_bits_ff       <= held_bits_in;
         press_latch_ff     <= press_latch_in;
         primary_held_ff    <= primary_held_in;
         accum_x_ff         <= accum_x_in;
         accum_y_ff         <= accum_y_in;
         contact_valid_ff   <= contact_valid_in;
         contact_owner_ff   <= contact_owner_in;
         contact_down_ff    <= contact_down_in;
         contact_latched_ff <= contact_latched_in;
         pos_x_ff           <= pos_x_in;
         pos_y_ff           <= pos_y_in;
         threshold_ff       <= threshold_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

endmodule

`default_nettype wire
